[rtl/ild_pkg.sv]
// ----------------------------------------------------------------------------
// ild_pkg - shared types and constants of the integer literal decoder
// Character codes, the classified token that runs from the front end to the
// back end, and the decode phase and radix codes.
// ----------------------------------------------------------------------------
package ild_pkg;

	// ASCII codes the front end looks for
	localparam logic [7:0] CHAR_SEP   = 8'h5F; // '_'
	localparam logic [7:0] CHAR_PLUS  = 8'h2B; // '+'
	localparam logic [7:0] CHAR_MINUS = 8'h2D; // '-'
	localparam logic [7:0] CHAR_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CHAR_NINE  = 8'h39; // '9'
	localparam logic [7:0] CHAR_LA    = 8'h61; // 'a'
	localparam logic [7:0] CHAR_LF    = 8'h66; // 'f'
	localparam logic [7:0] CHAR_UA    = 8'h41; // 'A'
	localparam logic [7:0] CHAR_UF    = 8'h46; // 'F'
	localparam logic [7:0] CHAR_LX    = 8'h78; // 'x'
	localparam logic [7:0] CHAR_UX    = 8'h58; // 'X'
	localparam logic [7:0] CHAR_LB    = 8'h62; // 'b'
	localparam logic [7:0] CHAR_UB    = 8'h42; // 'B'
	localparam logic [7:0] CHAR_LO    = 8'h6F; // 'o'
	localparam logic [7:0] CHAR_UO    = 8'h4F; // 'O'

	// digit value meaning "not a digit"
	localparam logic [4:0] DIGIT_NONE = 5'd16;

	localparam int MAG_W  = 64;
	localparam int PROD_W = MAG_W + 4; // magnitude times at most 16

	// one classified character
	typedef struct packed {
		logic       final_char;
		logic       is_sep;
		logic       is_plus;
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
		logic       is_b;
		logic       is_o;
		logic [4:0] digit;
	} token_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_SIGNED,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_HEX,
		RADIX_BIN,
		RADIX_OCT
	} radix_t;

endpackage

[rtl/ild_in_if.sv]
// ----------------------------------------------------------------------------
// ild_in_if - character channel
// One literal character per transfer, with the last-character mark.
// ----------------------------------------------------------------------------
interface ild_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       final_char;

	modport source (output valid, output character, output final_char, input ready);
	modport sink   (input valid, input character, input final_char, output ready);
endinterface

[rtl/ild_out_if.sv]
// ----------------------------------------------------------------------------
// ild_out_if - result channel
// One decoded value and its valid flag per transfer.
// ----------------------------------------------------------------------------
interface ild_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] decoded_value;
	logic               valid_res;

	modport source (output valid, output decoded_value, output valid_res, input ready);
	modport sink   (input valid, input decoded_value, input valid_res, output ready);
endinterface

[rtl/ild_queue.sv]
// ----------------------------------------------------------------------------
// ild_queue - token queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module ild_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ild_pkg::token_t push_data,
	output logic            full,
	output logic            not_empty,
	input  logic            pop,
	output ild_pkg::token_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ild_pkg::token_t  store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = store_q[rd_ptr_q];

	// storage, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
`endif

endmodule

[rtl/ild_front.sv]
// ----------------------------------------------------------------------------
// ild_front - character classifier
// Accepts characters and turns each into a token (digit value and class
// flags) that it writes into the token queue.
// ----------------------------------------------------------------------------
module ild_front (
	ild_in_if.sink          feed,
	input  logic            q_full,
	output logic            push,
	output ild_pkg::token_t push_data
);

	logic [7:0] c;

	assign c          = feed.character;
	assign feed.ready = !q_full;
	assign push       = feed.valid && !q_full;

	// classification
	always_comb begin
		push_data            = '0;
		push_data.final_char = feed.final_char;
		push_data.is_sep     = (c == ild_pkg::CHAR_SEP);
		push_data.is_plus    = (c == ild_pkg::CHAR_PLUS);
		push_data.is_minus   = (c == ild_pkg::CHAR_MINUS);
		push_data.is_zero    = (c == ild_pkg::CHAR_ZERO);
		push_data.is_x       = (c == ild_pkg::CHAR_LX) || (c == ild_pkg::CHAR_UX);
		push_data.is_b       = (c == ild_pkg::CHAR_LB) || (c == ild_pkg::CHAR_UB);
		push_data.is_o       = (c == ild_pkg::CHAR_LO) || (c == ild_pkg::CHAR_UO);
		if (c >= ild_pkg::CHAR_ZERO && c <= ild_pkg::CHAR_NINE) begin
			push_data.digit = 5'(c - ild_pkg::CHAR_ZERO);
		end else if (c >= ild_pkg::CHAR_LA && c <= ild_pkg::CHAR_LF) begin
			push_data.digit = 5'(c - ild_pkg::CHAR_LA) + 5'd10;
		end else if (c >= ild_pkg::CHAR_UA && c <= ild_pkg::CHAR_UF) begin
			push_data.digit = 5'(c - ild_pkg::CHAR_UA) + 5'd10;
		end else begin
			push_data.digit = ild_pkg::DIGIT_NONE;
		end
	end

endmodule

[rtl/ild_back.sv]
// ----------------------------------------------------------------------------
// ild_back - literal accumulator
// Takes tokens from the queue, runs the literal grammar, accumulates the
// magnitude with the range check, and holds the result in an output register.
// ----------------------------------------------------------------------------
module ild_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  ild_pkg::token_t tok,
	output logic            pop,
	ild_out_if.source       result
);

	ild_pkg::phase_t           phase_q, phase_n;
	ild_pkg::radix_t           radix_q, radix_n;
	logic                      neg_q, neg_n;
	logic [ild_pkg::MAG_W-1:0] mag_q, mag_n;
	logic                      sep_q, sep_n;
	logic                      failed_q, failed_n;

	logic                       out_valid_q;
	logic signed [63:0]         value_q;
	logic                       ok_q;

	logic [4:0]                 base;
	logic [ild_pkg::PROD_W-1:0] prod;
	logic [ild_pkg::PROD_W-1:0] new_mag;
	logic                       ovf;
	logic                       digit_ok;
	logic                       res_ok;
	logic [63:0]                res_value;

	// a token leaves the queue unless it is final and the result slot is held
	assign pop = q_not_empty && (!tok.final_char || !out_valid_q || result.ready);

	// magnitude times base plus digit, with the range check
	always_comb begin
		case (radix_q)
			ild_pkg::RADIX_DEC: begin
				base = 5'd10;
				prod = {mag_q, 3'b000, 1'b0} >> 1;
				prod = prod + {3'b000, mag_q, 1'b0};
			end
			ild_pkg::RADIX_HEX: begin
				base = 5'd16;
				prod = {mag_q, 4'b0000};
			end
			ild_pkg::RADIX_BIN: begin
				base = 5'd2;
				prod = {3'b000, mag_q, 1'b0};
			end
			ild_pkg::RADIX_OCT: begin
				base = 5'd8;
				prod = {1'b0, mag_q, 3'b000};
			end
			default: begin
				base = 5'd10;
				prod = '0;
			end
		endcase
		new_mag  = prod + ild_pkg::PROD_W'(tok.digit);
		// above 2^63-1, except exactly 2^63 for a negative literal
		ovf      = (|new_mag[ild_pkg::PROD_W-1:64])
			|| (new_mag[63] && !(neg_q && (new_mag[62:0] == '0)));
		digit_ok = (tok.digit < base) && !ovf;
	end

	// next state of the literal grammar
	always_comb begin
		phase_n  = phase_q;
		radix_n  = radix_q;
		neg_n    = neg_q;
		mag_n    = mag_q;
		sep_n    = sep_q;
		failed_n = failed_q;
		if (!failed_q) begin
			if (tok.is_sep) begin
				if (phase_q == ild_pkg::PH_START || sep_q || tok.final_char) begin
					failed_n = 1'b1;
				end
				sep_n = 1'b1;
			end else begin
				sep_n = 1'b0;
				case (phase_q)
					ild_pkg::PH_START, ild_pkg::PH_SIGNED: begin
						if (phase_q == ild_pkg::PH_START && (tok.is_plus || tok.is_minus)) begin
							neg_n   = tok.is_minus;
							phase_n = ild_pkg::PH_SIGNED;
						end else if (tok.is_zero) begin
							mag_n   = '0;
							phase_n = ild_pkg::PH_ZERO;
						end else if (digit_ok) begin
							mag_n   = new_mag[ild_pkg::MAG_W-1:0];
							phase_n = ild_pkg::PH_DIGITS;
						end else begin
							failed_n = 1'b1;
						end
					end
					ild_pkg::PH_ZERO: begin
						if (tok.is_x) begin
							radix_n = ild_pkg::RADIX_HEX;
							phase_n = ild_pkg::PH_PREFIX;
						end else if (tok.is_b) begin
							radix_n = ild_pkg::RADIX_BIN;
							phase_n = ild_pkg::PH_PREFIX;
						end else if (tok.is_o) begin
							radix_n = ild_pkg::RADIX_OCT;
							phase_n = ild_pkg::PH_PREFIX;
						end else if (digit_ok) begin
							mag_n   = new_mag[ild_pkg::MAG_W-1:0];
							phase_n = ild_pkg::PH_DIGITS;
						end else begin
							failed_n = 1'b1;
						end
					end
					default: begin
						if (digit_ok) begin
							mag_n   = new_mag[ild_pkg::MAG_W-1:0];
							phase_n = ild_pkg::PH_DIGITS;
						end else begin
							failed_n = 1'b1;
						end
					end
				endcase
			end
		end
	end

	// result of a final token
	always_comb begin
		res_ok    = !failed_n && (phase_n == ild_pkg::PH_ZERO || phase_n == ild_pkg::PH_DIGITS);
		res_value = '0;
		if (res_ok) begin
			res_value = neg_n ? (64'd0 - mag_n) : mag_n;
		end
	end

	// grammar state, back to start after each final token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ild_pkg::PH_START;
			radix_q  <= ild_pkg::RADIX_DEC;
			neg_q    <= 1'b0;
			mag_q    <= '0;
			sep_q    <= 1'b0;
			failed_q <= 1'b0;
		end else if (pop) begin
			if (tok.final_char) begin
				phase_q  <= ild_pkg::PH_START;
				radix_q  <= ild_pkg::RADIX_DEC;
				neg_q    <= 1'b0;
				mag_q    <= '0;
				sep_q    <= 1'b0;
				failed_q <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				radix_q  <= radix_n;
				neg_q    <= neg_n;
				mag_q    <= mag_n;
				sep_q    <= sep_n;
				failed_q <= failed_n;
			end
		end
	end

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && tok.final_char) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (pop && tok.final_char) begin
			value_q <= res_value;
			ok_q    <= res_ok;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.decoded_value = value_q;
	assign result.valid_res     = ok_q;

`ifndef SYNTHESIS
	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		pop && tok.final_char |=> phase_q == ild_pkg::PH_START && !failed_q && !sep_q
			&& mag_q == '0 && !neg_q)
		else $error("state not cleared after final token");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		pop && tok.final_char |-> !out_valid_q || result.ready)
		else $error("held result overwritten");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !ok_q |-> value_q == '0)
		else $error("invalid result with non-zero value");
`endif

endmodule

[rtl/integer_literal_decoder.sv]
// ----------------------------------------------------------------------------
// integer_literal_decoder - integer literal decoder, top level
// Decodes a signed 64-bit integer literal (sign, 0x/0b/0o prefix,
// underscore separators) given one character per transfer.
// ----------------------------------------------------------------------------
//
//  channel  role    payload                          transfer
//  -------  ------  -------------------------------  -----------------------
//  feed     sink    character[7:0], final_char       one literal character
//  result   source  decoded_value[63:0], valid_res   one per final character
//
//  One character per cycle sustained while the result is not stalled; the
//  accumulator takes one token a cycle (multiply by base plus digit and range
//  compare in one step). A final character's result passes the queue, then
//  the output register, before it is valid and can transfer.
//  Reset clears the queue, the grammar state and the result valid flag.
//  A stalled result holds back only final tokens; a held final token stops the
//  QUEUE_DEPTH-entry queue, which then fills and drops feed ready.
//
module integer_literal_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic       clk,
	input logic       arst_n,
	ild_in_if.sink    feed,
	ild_out_if.source result
);

	ild_pkg::token_t push_data;
	ild_pkg::token_t head;
	logic            push;
	logic            q_full;
	logic            q_not_empty;
	logic            pop;

	ild_front u_front (
		.feed      (feed),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	ild_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (pop),
		.head      (head)
	);

	ild_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.tok         (head),
		.pop         (pop),
		.result      (result)
	);

endmodule
